### rtl/cmpc_pkg.sv
package cmpc_pkg;

  localparam int SAMPLE_BITS     = 13;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 24;
  localparam int TABLE_FRAC      = 24;
  localparam int ZW              = 35;
  localparam int GAIN_ONE        = 4096;
  localparam int GAIN_MAX        = 65535;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_DIV,
    ST_THIRD,
    ST_DIVEND,
    ST_CENTER,
    ST_MUL,
    ST_SCALE,
    ST_CORDIC,
    ST_ROUND,
    ST_SMOOTH,
    ST_FIX,
    ST_FINISH
  } state_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(754974720);
      5'd1:  v = ZW'(445687602);
      5'd2:  v = ZW'(235489088);
      5'd3:  v = ZW'(119537938);
      5'd4:  v = ZW'(60000934);
      5'd5:  v = ZW'(30029717);
      5'd6:  v = ZW'(15018523);
      5'd7:  v = ZW'(7509720);
      5'd8:  v = ZW'(3754917);
      5'd9:  v = ZW'(1877466);
      5'd10: v = ZW'(938734);
      5'd11: v = ZW'(469367);
      5'd12: v = ZW'(234684);
      5'd13: v = ZW'(117342);
      5'd14: v = ZW'(58671);
      5'd15: v = ZW'(29335);
      5'd16: v = ZW'(14668);
      5'd17: v = ZW'(7334);
      5'd18: v = ZW'(3667);
      5'd19: v = ZW'(1833);
      5'd20: v = ZW'(917);
      5'd21: v = ZW'(458);
      5'd22: v = ZW'(229);
      5'd23: v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/compass_heading_with_calibration.sv
// Compass heading with hard-iron calibration. One transfer in gives one transfer out.
// Between taking a sample and loading its result, the back end runs, for a heading
// sample (s_tuser 1), the centre, multiply and scale steps, the 24-step CORDIC and the
// round and wrap steps, plus the divide by three when smoothing is on; the CORDIC is
// skipped when the corrected Y is zero. A calibration sample (s_tuser 0) widens the
// per-axis min/max and recomputes the Y gain with a bit-serial divider of
// max(SAMPLE_BITS + 12, ANGLE_FRAC_BITS + 13) bits, skipped when the Y range is zero. A stalled output holds
// the back end in its last cycle. A two-entry input queue and an output register
// decouple both sides.
module compass_heading_with_calibration #(
  parameter int SAMPLE_BITS     = cmpc_pkg::SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = cmpc_pkg::ANGLE_FRAC_BITS,
  localparam int IN_W           = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // raw_x, raw_y, raw_z
  input  logic            s_tuser,   // mode
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // heading_deg
  output logic            m_tuser    // heading_valid
);
  import cmpc_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int QW = 1 + 3 * S;

  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;
  logic [8:0]    heading;

  cmpc_front #(.W(QW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  ({s_tuser, s_tdata[3*S-1:0]}),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_data (q_data)
  );

  cmpc_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_mode  (q_data[3*S]),
    .in_x     (q_data[S-1:0]),
    .in_y     (q_data[2*S-1:S]),
    .in_z     (q_data[3*S-1:2*S]),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_heading(heading),
    .m_hvalid (m_tuser)
  );

  assign m_tdata = {7'd0, heading};

endmodule

### rtl/cmpc_front.sv
module cmpc_front #(
  parameter int W = 1 + 3 * cmpc_pkg::SAMPLE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  import cmpc_pkg::*;

  logic [W-1:0] slot [QUEUE_DEPTH];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign in_ready  = (count != 2'(QUEUE_DEPTH));
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

### rtl/cmpc_back.sv
module cmpc_back #(
  parameter int SAMPLE_BITS     = cmpc_pkg::SAMPLE_BITS,
  parameter int ANGLE_FRAC_BITS = cmpc_pkg::ANGLE_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [SAMPLE_BITS-1:0] in_x,
  input  logic [SAMPLE_BITS-1:0] in_y,
  input  logic [SAMPLE_BITS-1:0] in_z,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic [8:0]             m_heading,
  output logic                   m_hvalid
);
  import cmpc_pkg::*;

  localparam int S     = SAMPLE_BITS;
  localparam int AF    = ANGLE_FRAC_BITS;
  localparam int CW    = S + 2;
  localparam int PW    = CW + 17;
  localparam int YW    = PW - 12;
  localparam int XW    = YW + 18;
  localparam int SH    = TABLE_FRAC - AF;
  localparam int AW    = AF + 11;
  localparam int BW    = AF + 13;
  localparam int DW    = (S + 12 > BW) ? S + 12 : BW;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int K3    = (BW % 2 == 1) ? BW : BW + 1;
  localparam int PW3   = BW + K3;
  localparam logic [K3-1:0] M3 = K3'(((64'd1 << K3) + 64'd1) / 64'd3);
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd180 << TABLE_FRAC);
  localparam logic signed [ZW-1:0] RND  = ZW'((64'd1 << SH) >> 1);
  localparam logic signed [AW-1:0] D180 = AW'(64'd180 << AF);
  localparam logic signed [AW-1:0] D360 = AW'(64'd360 << AF);

  state_t state, state_next;

  logic                 smoothing_on;
  logic                 mode;
  logic signed [S-1:0]  sx, sy, sz;
  logic signed [S-1:0]  amax [3];
  logic signed [S-1:0]  amin [3];
  logic [15:0]          gain;
  logic signed [AW-1:0] sm;
  logic signed [AW-1:0] ang;
  logic signed [AW-1:0] tmp;
  logic signed [CW-1:0] cx, cy0;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz;
  logic [CNT_W-1:0]     cnt;
  logic [DW-1:0]        dq, dden;
  logic [DW-1:0]        drem;
  logic                 div_cal;
  logic                 bneg;
  logic                 out_load;

  // calibration
  logic signed [S-1:0] nmax [3];
  logic signed [S-1:0] nmin [3];
  logic signed [S-1:0] samp [3];
  logic [S-1:0]        xr, yr;

  always_comb begin
    samp[0] = sx;
    samp[1] = sy;
    samp[2] = sz;
    for (int i = 0; i < 3; i++) begin
      nmax[i] = (samp[i] > amax[i]) ? samp[i] : amax[i];
      nmin[i] = (samp[i] < amin[i]) ? samp[i] : amin[i];
    end
    xr = S'(nmax[0] - nmin[0]);
    yr = S'(nmax[1] - nmin[1]);
  end

  // midpoints, truncated toward zero
  logic signed [S:0]   msum0, msum1;
  logic signed [S-1:0] mid0, mid1;
  always_comb begin
    msum0 = S'(0) + {amax[0][S-1], amax[0]} + {amin[0][S-1], amin[0]};
    msum1 = S'(0) + {amax[1][S-1], amax[1]} + {amin[1][S-1], amin[1]};
    mid0  = S'((msum0 + (S+1)'(msum0[S])) >>> 1);
    mid1  = S'((msum1 + (S+1)'(msum1[S])) >>> 1);
  end

  // gain scaling, truncated toward zero
  logic signed [PW-1:0] pbias;
  logic signed [YW-1:0] cy_s;
  always_comb begin
    pbias = prod + (prod[PW-1] ? PW'(4095) : PW'(0));
    cy_s  = YW'(pbias >>> 12);
  end

  // divider step
  logic [DW:0] dtrial;
  logic        dfit;
  always_comb begin
    dtrial = {drem, dq[DW-1]};
    dfit   = dtrial >= {1'b0, dden};
  end

  // divide by three through a reciprocal multiply
  logic [PW3-1:0] prod3;
  assign prod3 = PW3'(dq[BW-1:0]) * PW3'(M3);

  // cordic step
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zt;
  always_comb begin
    xs = cx_r >>> cnt[4:0];
    ys = cy_r >>> cnt[4:0];
    zt = atan_entry(cnt[4:0]);
  end

  // round and offset
  logic signed [ZW-1:0] zr;
  always_comb begin
    zr = (cz + RND) >>> SH;
  end

  // blend set-up
  logic signed [AW-1:0] dif, adif, oldv;
  logic signed [BW-1:0] bsum;
  logic [BW-1:0]        bmag;
  always_comb begin
    dif  = sm - ang;
    adif = dif[AW-1] ? -dif : dif;
    oldv = sm;
    if (adif > D180) begin
      oldv = (ang < D180) ? sm - D360 : sm + D360;
    end
    bsum = BW'(oldv) + BW'(oldv) + BW'(ang);
    bmag = bsum[BW-1] ? BW'(-bsum) : BW'(bsum);
  end

  // blend wrap
  logic signed [AW-1:0] bq, b1, b2, b3, b4;
  always_comb begin
    bq = bneg ? -AW'(dq) : AW'(dq);
    b1 = (bq < 0) ? bq + D360 : bq;
    b2 = (b1 < 0) ? b1 + D360 : b1;
    b3 = (b2 >= D360) ? b2 - D360 : b2;
    b4 = (b3 >= D360) ? b3 - D360 : b3;
  end

  logic signed [AW-1:0] f1, f2;
  always_comb begin
    f1 = (tmp < 0) ? tmp + D360 : tmp;
    f2 = (f1 > D360) ? f1 - D360 : f1;
  end

  logic out_free;
  assign out_free = !m_valid || m_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = in_mode ? ST_CENTER : ST_CAL;
      ST_CAL:    state_next = (yr != '0) ? ST_DIV : ST_FINISH;
      ST_DIV:    if (cnt == CNT_W'(DW - 1)) state_next = ST_DIVEND;
      ST_THIRD:  state_next = ST_DIVEND;
      ST_DIVEND: state_next = div_cal ? ST_FINISH : ST_FIX;
      ST_CENTER: state_next = ST_MUL;
      ST_MUL:    state_next = ST_SCALE;
      ST_SCALE:  state_next = (cy_s == '0) ? ST_ROUND : ST_CORDIC;
      ST_CORDIC: if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = smoothing_on ? ST_THIRD : ST_FIX;
      ST_FIX:    state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_load = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      smoothing_on <= 1'b0;
      m_valid      <= 1'b0;
      gain         <= 16'(GAIN_ONE);
      sm           <= '0;
      for (int i = 0; i < 3; i++) begin
        amax[i] <= '0;
        amin[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) smoothing_on <= cfg_wdata;
      if (out_load) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
      if (state == ST_CAL) begin
        for (int i = 0; i < 3; i++) begin
          amax[i] <= nmax[i];
          amin[i] <= nmin[i];
        end
      end
      if (state == ST_DIVEND && div_cal) begin
        gain <= (dq > DW'(GAIN_MAX)) ? 16'(GAIN_MAX) : dq[15:0];
      end
      if (state == ST_FIX) sm <= f2;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode <= in_mode;
        sx   <= in_x;
        sy   <= in_y;
        sz   <= in_z;
      end
      ST_CAL: begin
        dq      <= DW'(xr) << 12;
        drem    <= '0;
        dden    <= DW'(yr);
        div_cal <= 1'b1;
        cnt     <= '0;
      end
      ST_DIV: begin
        drem <= dfit ? DW'(dtrial - {1'b0, dden}) : dtrial[DW-1:0];
        dq   <= {dq[DW-2:0], dfit};
        cnt  <= cnt + 1'b1;
      end
      ST_THIRD: begin
        dq <= DW'(prod3 >> K3);
      end
      ST_DIVEND: begin
        tmp <= b4;
      end
      ST_CENTER: begin
        cx  <= CW'(sx) - CW'(mid0);
        cy0 <= CW'(sy) - CW'(mid1);
      end
      ST_MUL: begin
        prod <= PW'(cy0) * PW'($signed({1'b0, gain}));
      end
      ST_SCALE: begin
        cnt <= '0;
        if (cy_s == '0) begin
          cz <= (cx < 0) ? HALF : '0;
        end else if (cx < 0) begin
          cz   <= (cy_s > 0) ? HALF : -HALF;
          cx_r <= -(XW'(cx) <<< 16);
          cy_r <= -(XW'(cy_s) <<< 16);
        end else begin
          cz   <= '0;
          cx_r <= XW'(cx) <<< 16;
          cy_r <= XW'(cy_s) <<< 16;
        end
      end
      ST_CORDIC: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz   <= cz + zt;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz   <= cz - zt;
        end
        cnt <= cnt + 1'b1;
      end
      ST_ROUND: begin
        ang <= AW'(zr) + D180;
      end
      ST_SMOOTH: begin
        tmp     <= ang;
        dq      <= DW'(bmag);
        bneg    <= bsum[BW-1];
        div_cal <= 1'b0;
      end
      ST_FINISH: begin
        if (out_free) begin
          m_hvalid  <= mode;
          m_heading <= mode ? 9'(sm >>> AF) : 9'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

### verif/compass_heading_with_calibration_tb.sv
`timescale 1ns / 1ps

module compass_heading_with_calibration_tb;
  import cmpc_pkg::*;

  localparam int IN_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;
  localparam bit MODE_CAL = 1'b0;
  localparam bit MODE_HEADING = 1'b1;
  localparam int SETTLE_CYCLES = 120;
  localparam int LONG_HOLD = 400;
  localparam int STALL_LIMIT = 5000;
  localparam longint DEG180 = longint'(180) <<< ANGLE_FRAC_BITS;
  localparam longint DEG360 = longint'(360) <<< ANGLE_FRAC_BITS;
  localparam longint HALF_TURN = longint'(180) <<< TABLE_FRAC;
  localparam longint ATAN_DEG [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  typedef struct {
    logic [8:0] heading_deg;
    logic       heading_valid;
  } heading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;

  heading_t expected_headings[$];
  longint axis_hi[3];
  longint axis_lo[3];
  longint gain_q12;
  longint heading_acc;
  bit smooth_en;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit long_hold = 1'b0;
  int errors = 0;
  int stall_cycles = 0;

  compass_heading_with_calibration DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  function automatic longint cordic_atan2(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    if (y == 0) return (x < 0) ? HALF_TURN : 0;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG[i];
      end
    end
    return z;
  endfunction

  task automatic predict_heading(input bit mode, input logic [12:0] rx, input logic [12:0] ry,
                                 input logic [12:0] rz);
    longint s[3];
    longint cx, cy, z, ang, prev, diff, b, g;
    heading_t r;
    s[0] = longint'($signed(rx));
    s[1] = longint'($signed(ry));
    s[2] = longint'($signed(rz));
    if (mode == MODE_CAL) begin
      for (int i = 0; i < 3; i++) begin
        if (s[i] > axis_hi[i]) axis_hi[i] = s[i];
        if (s[i] < axis_lo[i]) axis_lo[i] = s[i];
      end
      if (axis_hi[1] != axis_lo[1]) begin
        g = ((axis_hi[0] - axis_lo[0]) * GAIN_ONE) / (axis_hi[1] - axis_lo[1]);
        gain_q12 = (g > GAIN_MAX) ? GAIN_MAX : g;
      end
      r.heading_deg = '0;
      r.heading_valid = 1'b0;
    end else begin
      cx = s[0] - (axis_hi[0] + axis_lo[0]) / 2;
      cy = s[1] - (axis_hi[1] + axis_lo[1]) / 2;
      cy = (cy * gain_q12) / GAIN_ONE;
      z = cordic_atan2(cy, cx);
      z = (z + (longint'(1) <<< (TABLE_FRAC - ANGLE_FRAC_BITS - 1)))
          >>> (TABLE_FRAC - ANGLE_FRAC_BITS);
      ang = z + DEG180;
      if (smooth_en) begin
        prev = heading_acc;
        diff = prev - ang;
        if (diff < 0) diff = -diff;
        if (diff > DEG180) prev = (ang < DEG180) ? prev - DEG360 : prev + DEG360;
        b = (2 * prev + ang) / 3;
        if (b < 0) b += DEG360;
        if (b < 0) b += DEG360;
        if (b >= DEG360) b -= DEG360;
        if (b >= DEG360) b -= DEG360;
        heading_acc = b;
      end else begin
        heading_acc = ang;
      end
      if (heading_acc < 0) heading_acc += DEG360;
      if (heading_acc > DEG360) heading_acc -= DEG360;
      r.heading_deg = 9'(heading_acc >>> ANGLE_FRAC_BITS);
      r.heading_valid = 1'b1;
    end
    expected_headings.push_back(r);
  endtask

  task automatic send_sample(input bit mode, input logic [12:0] rx, input logic [12:0] ry,
                             input logic [12:0] rz);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {{(IN_W - 39){1'b0}}, rz, ry, rx};
    do @(posedge clk); while (!s_tready);
    predict_heading(mode, rx, ry, rz);
  endtask

  task automatic send_random(input int cal_pct);
    bit mode;
    mode = ($urandom_range(0, 99) < cal_pct) ? MODE_CAL : MODE_HEADING;
    send_sample(mode, 13'($urandom), 13'($urandom), 13'($urandom));
  endtask

  task automatic set_smoothing(input bit v);
    s_tvalid <= 1'b0;
    wait (expected_headings.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    smooth_en = v;
  endtask

  task automatic test_directed_special_cases();
    send_sample(MODE_HEADING, 13'sd100, 13'sd0, 13'sd0);
    send_sample(MODE_HEADING, -13'sd100, 13'sd0, 13'sd0);
    send_sample(MODE_HEADING, 13'sd0, 13'sd0, 13'sd0);
    send_sample(MODE_HEADING, 13'sd4095, 13'sd4095, 13'sd4095);
    send_sample(MODE_HEADING, -13'sd4096, -13'sd4096, -13'sd4096);
    send_sample(MODE_HEADING, 13'sd4095, -13'sd4096, 13'sd0);
    send_sample(MODE_CAL, 13'sd100, 13'sd0, 13'sd5);
    send_sample(MODE_HEADING, 13'sd20, 13'sd7, 13'sd0);
    send_sample(MODE_CAL, 13'sd4095, 13'sd1, -13'sd4096);
    send_sample(MODE_HEADING, 13'sd30, 13'sd1, 13'sd0);
    send_sample(MODE_HEADING, -13'sd4096, 13'sd2, 13'sd0);
    send_sample(MODE_CAL, -13'sd4096, -13'sd4096, 13'sd4095);
    send_sample(MODE_HEADING, -13'sd4096, 13'sd0, 13'sd1);
    send_sample(MODE_HEADING, 13'sd1000, -13'sd30, 13'sd0);
  endtask

  task automatic test_smoothing_wrap();
    set_smoothing(1'b1);
    send_sample(MODE_HEADING, -13'sd4000, 13'sd40, 13'sd0);
    send_sample(MODE_HEADING, -13'sd4000, -13'sd40, 13'sd0);
    send_sample(MODE_HEADING, -13'sd4000, 13'sd40, 13'sd0);
    send_sample(MODE_HEADING, 13'sd4000, 13'sd0, 13'sd0);
    send_sample(MODE_HEADING, -13'sd4000, 13'sd0, 13'sd0);
    send_sample(MODE_HEADING, -13'sd4000, -13'sd2, 13'sd0);
    send_sample(MODE_HEADING, 13'sd100, 13'sd4095, 13'sd0);
  endtask

  task automatic test_random_mix(input bit smooth, input int count);
    set_smoothing(smooth);
    for (int i = 0; i < count; i++) begin
      tx_gaps = ((i / 40) % 2) == 0;
      rx_gaps = ((i / 55) % 2) == 0;
      send_random(25);
    end
  endtask

  task automatic test_output_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 8; i++) send_random(30);
  endtask

  task automatic test_no_idle_tail();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < 110; i++) send_random(20);
  endtask

  initial begin
    axis_hi = '{0, 0, 0};
    axis_lo = '{0, 0, 0};
    gain_q12 = GAIN_ONE;
    heading_acc = 0;
    smooth_en = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_special_cases();
    test_smoothing_wrap();
    test_random_mix(1'b0, 200);
    test_output_backpressure();
    test_random_mix(1'b1, 200);
    test_random_mix(1'b0, 60);
    set_smoothing(1'b1);
    test_no_idle_tail();
    s_tvalid <= 1'b0;
    wait (expected_headings.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    heading_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_headings.size() == 0) begin
        $error("unexpected transfer: heading_deg %0d heading_valid %0d",
               m_tdata[8:0], m_tuser);
        errors++;
      end else begin
        exp_r = expected_headings.pop_front();
        if (m_tdata[8:0] !== exp_r.heading_deg) begin
          $error("heading_deg expected %0d actual %0d", exp_r.heading_deg, m_tdata[8:0]);
          errors++;
        end
        if (m_tuser !== exp_r.heading_valid) begin
          $error("heading_valid expected %0d actual %0d", exp_r.heading_valid, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
